// ----- rtl/core/bb3_pkg.sv -----
// Shared constants, types and helper functions for the 3x3 box blur.
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_W_W   = 11;
    localparam int CFG_H_W   = 16;
    localparam int WEFF_W    = (COL_W + 1 > CFG_W_W) ? COL_W + 1 : CFG_W_W;
    localparam int ROW_W     = CFG_H_W + 1;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int RCP_W     = 18;
    localparam int RCP_SHIFT = 18;
    localparam int NUM_W     = SUM_W + 1;
    localparam int PROD_W    = NUM_W + RCP_W;

    localparam logic [2:0] REG_ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] REG_ADDR_HEIGHT = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [2:0][7:0]       t_pix;
    typedef logic [2:0][SUM_W-1:0] t_sum;

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_mask;

    typedef struct packed {
        logic  emit;
        logic  done;
        t_mask mask;
    } t_ctl;

    // 2^18 / (2 * count), rounded up; exact for every numerator below 2^15.
    function automatic logic [RCP_W-1:0] bb3_recip(input logic [CNT_W-1:0] count);
        logic [RCP_W-1:0] m;
        begin
            unique case (count)
                4'd1:    m = 18'd131072;
                4'd2:    m = 18'd65536;
                4'd3:    m = 18'd43691;
                4'd4:    m = 18'd32768;
                4'd6:    m = 18'd21846;
                4'd9:    m = 18'd14564;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

// ----- rtl/core/bb3_line_ram.sv -----
// Line store memory: upper and middle rows packed per column, with a registered read.
`timescale 1ns / 1ps

module bb3_line_ram
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output logic [47:0]      o_rd_data,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  logic [47:0]      i_wr_data
);

    logic [47:0] r_mem [MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/core/bb3_window.sv -----
// 3x3 pixel window: shift in a new column and sum the in-frame neighbors.
`timescale 1ns / 1ps

module bb3_window
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_pix             i_up,
    input  t_pix             i_mid,
    input  t_pix             i_pix,
    input  t_mask            i_mask,
    output t_sum             o_sum,
    output logic [CNT_W-1:0] o_count
);

    t_pix r_win [3][3];
    t_pix n_win [3][3];
    t_pix new_col [3];
    logic [2:0] row_en;
    logic [2:0] col_en;

    always_comb begin
        new_col[0] = i_up;
        new_col[1] = i_mid;
        new_col[2] = i_pix;
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
            n_win[r][2] = new_col[r];
        end
    end

    assign row_en = {i_mask.bot, 1'b1, i_mask.top};
    assign col_en = {i_mask.right, 1'b1, i_mask.left};

    // Sum over the window as it stands after the shift.
    always_comb begin
        o_sum   = '0;
        o_count = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                if (row_en[r] && col_en[k]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        o_sum[ch] = o_sum[ch] + SUM_W'(n_win[r][k][ch]);
                    end
                    o_count = o_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else if (i_en) begin
            r_win <= n_win;
        end
    end

endmodule

// ----- rtl/core/bb3_divide.sv -----
// Rounded mean per channel: (2*sum+count)/(2*count) by reciprocal multiply.
`timescale 1ns / 1ps

module bb3_divide
    import bb3_pkg::*;
(
    input  t_sum             i_sum,
    input  logic [CNT_W-1:0] i_count,
    output t_pix             o_mean
);

    logic [RCP_W-1:0]  recip;
    logic [NUM_W-1:0]  num  [3];
    logic [PROD_W-1:0] prod [3];

    assign recip = bb3_recip(i_count);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            num[ch]    = {i_sum[ch], 1'b0} + NUM_W'(i_count);
            prod[ch]   = PROD_W'(num[ch]) * PROD_W'(recip);
            o_mean[ch] = prod[ch][RCP_SHIFT +: 8];
        end
    end

endmodule

// ----- rtl/core/box_blur_3x3_rgb.sv -----
// Streaming 3x3 box blur over RGB frames with two line stores and a sliding window.
`timescale 1ns / 1ps

// Pixels enter in raster order for a frame of frame_width x frame_height; each
// result is the per-channel mean of the pixel's in-frame 3x3 neighborhood (9
// inside, 6 on an edge, 4 in a corner), rounded half up. A result for a pixel
// leaves once the input has moved one row plus one pixel past it, so after the
// last pixel send frame_width + 1 drain transactions (cmd = 1) to flush the
// frame; the last result carries frame_done and the block is then ready for
// the next frame. A drain transaction sent before the frame is complete is
// taken and dropped; a pixel sent after the frame is complete counts as a
// drain. The block takes one transaction per clock while o_stall is low. Each
// accepted transaction goes through a read of the line store memory, a
// window/sum stage, and a divide stage into the output register. The line
// store has one read and one write port; back-to-back accesses to the same
// column (a width of one) are served by forwarding. Input stalls only when a
// result is ready to leave the divide stage while the output register is
// held. Writing either register through the APB port restarts the frame;
// write only while idle. Register 0 at address 0 is frame_width (0 acts as
// 1, values above 1024 act as 1024); register 1 at address 4 is
// frame_height (0 acts as 1).

module box_blur_3x3_rgb
    import bb3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input pixel channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    // output pixel channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic        o_frame_done,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------- config
    logic [CFG_W_W-1:0] r_width;
    logic [CFG_H_W-1:0] r_height;
    logic               cfg_wr;
    logic [WEFF_W-1:0]  w_ext;
    logic [WEFF_W-1:0]  w_eff;
    logic [CFG_H_W-1:0] h_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W_W'(1);
            r_height <= CFG_H_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_height <= pwdata[CFG_H_W-1:0];
            end else begin
                r_width <= pwdata[CFG_W_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr == REG_ADDR_HEIGHT) begin
            prdata = 32'(r_height);
        end else if (paddr == REG_ADDR_WIDTH) begin
            prdata = 32'(r_width);
        end else if (paddr[2]) begin
            prdata = 32'(r_height);
        end else begin
            prdata = 32'(r_width);
        end
    end

    // Clamp the frame size to what the line stores can hold.
    assign w_ext = WEFF_W'(r_width);
    always_comb begin
        priority if (w_ext == '0) begin
            w_eff = WEFF_W'(1);
        end else if (w_ext > WEFF_W'(MAX_WIDTH)) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
    end
    assign h_eff = (r_height == '0) ? CFG_H_W'(1) : r_height;

    // ------------------------------------------------------------ flow control
    logic r_s1_v;
    logic r_s2_v;
    logic r_ov;
    logic adv;
    logic accept;
    logic take;

    // Hold the whole pipe only when a result must enter a held output register.
    assign adv     = !(r_s2_v && r_ov && i_stall);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // ---------------------------------------------------------- stage 0: input
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [CFG_H_W-1:0] r_out_row, n_out_row;
    logic  active;
    logic  ignore;
    logic  col_last;
    t_pix  pix;
    t_ctl  ctl;

    assign active = r_in_row < ROW_W'(h_eff);
    assign ignore = active && (i_cmd == CMD_DRAIN);
    assign take   = accept && !ignore;
    assign pix    = active ? {i_in_red, i_in_green, i_in_blue} : '0;

    assign col_last = (WEFF_W'(r_in_col) + WEFF_W'(1)) >= w_eff;

    always_comb begin
        ctl.emit       = ((r_in_row != '0) && (r_in_col != '0))
                      || ((|r_in_row[ROW_W-1:1]) && (r_in_col == '0));
        ctl.mask.top   = r_out_row != '0;
        ctl.mask.bot   = (ROW_W'(r_out_row) + ROW_W'(1)) < ROW_W'(h_eff);
        ctl.mask.left  = r_out_col != '0;
        ctl.mask.right = (WEFF_W'(r_out_col) + WEFF_W'(1)) < w_eff;
        ctl.done       = !ctl.mask.bot && !ctl.mask.right;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (take) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (ctl.emit) begin
                priority if (ctl.done) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (!ctl.mask.right) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + CFG_H_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
        end
        // A register write restarts the frame.
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // -------------------------------------------- stage 1: line store + window
    logic [COL_W-1:0] r_s1_col;
    t_pix             r_s1_pix;
    t_ctl             r_s1_ctl;
    logic             r_s1_fwd;
    logic [47:0]      r_fwd_data;
    logic [47:0]      ram_q;
    logic [47:0]      store_q;
    logic             s1_go;
    t_pix             up_px;
    t_pix             mid_px;
    t_sum             win_sum;
    logic [CNT_W-1:0] win_count;

    assign s1_go = adv && r_s1_v;

    bb3_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_q),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({mid_px, r_s1_pix})
    );

    // Take the column just written when the read raced that write.
    assign store_q = r_s1_fwd ? r_fwd_data : ram_q;
    assign up_px   = store_q[47:24];
    assign mid_px  = store_q[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && take) begin
            r_s1_col <= r_in_col;
            r_s1_pix <= pix;
            r_s1_ctl <= ctl;
            r_s1_fwd <= r_s1_v && (r_in_col == r_s1_col);
        end
        if (s1_go) begin
            r_fwd_data <= {mid_px, r_s1_pix};
        end
    end

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_go),
        .i_up    (up_px),
        .i_mid   (mid_px),
        .i_pix   (r_s1_pix),
        .i_mask  (r_s1_ctl.mask),
        .o_sum   (win_sum),
        .o_count (win_count)
    );

    // ------------------------------------------------------- stage 2: divide
    t_sum             r_s2_sum;
    logic [CNT_W-1:0] r_s2_count;
    logic             r_s2_done;
    t_pix             mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (adv) begin
            r_s2_v <= r_s1_v && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctl.emit) begin
            r_s2_sum   <= win_sum;
            r_s2_count <= win_count;
            r_s2_done  <= r_s1_ctl.done;
        end
    end

    bb3_divide u_divide (
        .i_sum   (r_s2_sum),
        .i_count (r_s2_count),
        .o_mean  (mean)
    );

    // ------------------------------------------------------- output register
    t_pix r_out_pix;
    logic r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv && r_s2_v) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_v) begin
            r_out_pix  <= mean;
            r_out_done <= r_s2_done;
        end
    end

    assign o_valid      = r_ov;
    assign o_out_red    = r_out_pix[2];
    assign o_out_green  = r_out_pix[1];
    assign o_out_blue   = r_out_pix[0];
    assign o_frame_done = r_out_done;

endmodule
